### hw/rtl/iat_pkg.sv
// Shared types and codes for the indexed array table.
`default_nettype none

package iat_pkg;

    typedef enum logic [2:0] {
        FN_INS_AT    = 3'd0,
        FN_INS_FRONT = 3'd1,
        FN_INS_BACK  = 3'd2,
        FN_DEL_AT    = 3'd3,
        FN_READ      = 3'd4,
        FN_FIND      = 3'd5,
        FN_SET_LEN   = 3'd6,
        FN_NOP       = 3'd7
    } t_func;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_FULL     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_NOTFOUND = 3'd5
    } t_status;

    typedef enum logic {
        REG_MIN_VALUE = 1'b0,
        REG_MAX_VALUE = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic start;
        logic step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic run;
        logic done;
    } t_dp_sts;

endpackage

`default_nettype wire

### hw/rtl/iat_if.sv
// Request, response and configuration channel interfaces.
`default_nettype none

interface iat_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic [6:0]         position;
    logic signed [31:0] value;

    modport source(output valid, output func, output position, output value, input ready);
    modport sink(input valid, input func, input position, input value, output ready);
endinterface

interface iat_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] read_data;
    logic [5:0]         found_index;
    logic [6:0]         length_now;

    modport source(output valid, output status, output read_data, output found_index,
                   output length_now, input ready);
    modport sink(input valid, input status, input read_data, input found_index,
                 input length_now, output ready);
endinterface

interface iat_cfg_if;
    logic               valid;
    logic               ready;
    logic               index;
    logic [31:0]        data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/iat_datapath.sv
// Datapath: entry memory, length, limits, sweep counter and result registers.
`default_nettype none

module iat_datapath #(
    parameter int DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire iat_pkg::t_dp_cmd   i_cmd,
    output iat_pkg::t_dp_sts        o_sts,
    input  wire logic [2:0]         i_func,
    input  wire logic [6:0]         i_position,
    input  wire logic signed [31:0] i_value,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    output logic [2:0]              o_status,
    output logic signed [31:0]      o_read_data,
    output logic [5:0]              o_found_index,
    output logic [6:0]              o_length_now
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > 7) ? LW : 7;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [31:0] mem [DEPTH];

    iat_pkg::t_func     r_func;
    logic [6:0]         r_pos;
    logic signed [31:0] r_val;
    logic signed [31:0] r_min, n_min;
    logic signed [31:0] r_max, n_max;
    logic [LW-1:0]      r_len, n_len;
    logic [LW-1:0]      r_idx, n_idx;
    logic [LW-1:0]      r_tgt, n_tgt;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_wr_addr, n_wr_addr;
    logic [31:0]        r_rd_data;
    iat_pkg::t_status   r_status, n_status;
    logic [31:0]        r_rdata, n_rdata;
    logic [5:0]         r_fidx, n_fidx;
    iat_pkg::t_status   r_o_status;
    logic [31:0]        r_o_rdata;
    logic [5:0]         r_o_fidx;
    logic [6:0]         r_o_len;

    logic [CW-1:0]      pos_c, len_c;
    logic               val_ok, full;
    iat_pkg::t_status   chk_status;
    logic               run;
    logic [LW-1:0]      tgt_c;
    logic [LW-1:0]      idx_inc, idx_dec;
    logic               hit, done;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_wa, mem_ra;
    logic [31:0]        mem_wd;

    assign pos_c   = CW'(r_pos);
    assign len_c   = CW'(r_len);
    assign val_ok  = (r_val >= r_min) && (r_val <= r_max);
    assign full    = (len_c == DEPTH_C);
    assign idx_inc = r_idx + LW'(1);
    assign idx_dec = r_idx - LW'(1);
    assign hit     = r_pend && (r_rd_data == r_val);

    always_comb begin
        chk_status = iat_pkg::ST_OK;
        run        = 1'b0;
        tgt_c      = LW'(r_pos);
        case (r_func)
            iat_pkg::FN_INS_AT: begin
                if (pos_c > len_c) chk_status = iat_pkg::ST_BADPOS;
                else if (full) chk_status = iat_pkg::ST_FULL;
                else if (!val_ok) chk_status = iat_pkg::ST_RANGE;
                run = 1'b1;
            end
            iat_pkg::FN_INS_FRONT, iat_pkg::FN_INS_BACK: begin
                if (!val_ok) chk_status = iat_pkg::ST_RANGE;
                else if (full) chk_status = iat_pkg::ST_FULL;
                run   = 1'b1;
                tgt_c = (r_func == iat_pkg::FN_INS_FRONT) ? '0 : r_len;
            end
            iat_pkg::FN_DEL_AT: begin
                if (pos_c >= len_c) chk_status = iat_pkg::ST_BADPOS;
                run = 1'b1;
            end
            iat_pkg::FN_READ: begin
                if (r_len == '0) chk_status = iat_pkg::ST_EMPTY;
                else if (pos_c >= len_c) chk_status = iat_pkg::ST_BADPOS;
                run = 1'b1;
            end
            iat_pkg::FN_FIND: begin
                if (!val_ok) chk_status = iat_pkg::ST_RANGE;
                run = 1'b1;
            end
            iat_pkg::FN_SET_LEN: begin
                if (pos_c > DEPTH_C) chk_status = iat_pkg::ST_BADPOS;
                run = (pos_c > len_c);
            end
            default: begin
                run = 1'b0;
            end
        endcase
    end

    assign o_sts.run  = run && (chk_status == iat_pkg::ST_OK);
    assign o_sts.done = done;

    always_comb begin
        n_min     = r_min;
        n_max     = r_max;
        n_len     = r_len;
        n_idx     = r_idx;
        n_tgt     = r_tgt;
        n_pend    = r_pend;
        n_wr_addr = r_wr_addr;
        n_status  = r_status;
        n_rdata   = r_rdata;
        n_fidx    = r_fidx;
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = '0;
        mem_re    = 1'b0;
        mem_ra    = '0;
        done      = 1'b0;

        if (i_cfg_we) begin
            case (iat_pkg::t_reg_idx'(i_cfg_index))
                iat_pkg::REG_MIN_VALUE: n_min = i_cfg_data;
                iat_pkg::REG_MAX_VALUE: n_max = i_cfg_data;
                default: n_min = r_min;
            endcase
        end

        case (r_func)
            iat_pkg::FN_INS_AT, iat_pkg::FN_INS_FRONT, iat_pkg::FN_INS_BACK: begin
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_wr_addr;
                    mem_wd = r_rd_data;
                end else if (r_idx == r_tgt) begin
                    mem_we = 1'b1;
                    mem_wa = r_tgt[AW-1:0];
                    mem_wd = r_val;
                    n_len  = r_len + LW'(1);
                    done   = 1'b1;
                end
                if (r_idx != r_tgt) begin
                    mem_re    = 1'b1;
                    mem_ra    = idx_dec[AW-1:0];
                    n_pend    = 1'b1;
                    n_wr_addr = r_idx[AW-1:0];
                    n_idx     = idx_dec;
                end else begin
                    n_pend = 1'b0;
                end
            end
            iat_pkg::FN_DEL_AT: begin
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_wr_addr;
                    mem_wd = r_rd_data;
                end
                if (idx_inc < r_len) begin
                    mem_re    = 1'b1;
                    mem_ra    = idx_inc[AW-1:0];
                    n_pend    = 1'b1;
                    n_wr_addr = r_idx[AW-1:0];
                    n_idx     = idx_inc;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_len = r_len - LW'(1);
                        done  = 1'b1;
                    end
                end
            end
            iat_pkg::FN_READ: begin
                if (!r_pend) begin
                    mem_re = 1'b1;
                    mem_ra = r_tgt[AW-1:0];
                    n_pend = 1'b1;
                end else begin
                    n_rdata = r_rd_data;
                    done    = 1'b1;
                end
            end
            iat_pkg::FN_FIND: begin
                if (r_idx < r_len) begin
                    mem_re    = 1'b1;
                    mem_ra    = r_idx[AW-1:0];
                    n_pend    = 1'b1;
                    n_wr_addr = r_idx[AW-1:0];
                    n_idx     = idx_inc;
                end else begin
                    n_pend = 1'b0;
                end
                if (hit) begin
                    n_status = iat_pkg::ST_OK;
                    n_fidx   = 6'(r_wr_addr);
                    done     = 1'b1;
                end else if (!r_pend && (r_idx >= r_len)) begin
                    done = 1'b1;
                end
            end
            iat_pkg::FN_SET_LEN: begin
                if (r_idx < r_tgt) begin
                    mem_we = 1'b1;
                    mem_wa = r_idx[AW-1:0];
                    mem_wd = '0;
                    n_idx  = idx_inc;
                end else begin
                    n_len = r_tgt;
                    done  = 1'b1;
                end
            end
            default: begin
                done = 1'b1;
            end
        endcase

        if (!i_cmd.step) begin
            n_len     = r_len;
            n_idx     = r_idx;
            n_pend    = r_pend;
            n_wr_addr = r_wr_addr;
            n_status  = r_status;
            n_rdata   = r_rdata;
            n_fidx    = r_fidx;
            mem_we    = 1'b0;
            mem_re    = 1'b0;
        end

        if (i_cmd.start) begin
            n_status = ((r_func == iat_pkg::FN_FIND) && (chk_status == iat_pkg::ST_OK))
                       ? iat_pkg::ST_NOTFOUND : chk_status;
            n_rdata  = '0;
            n_fidx   = '0;
            n_pend   = 1'b0;
            n_tgt    = tgt_c;
            if (r_func == iat_pkg::FN_DEL_AT) n_idx = tgt_c;
            else if (r_func == iat_pkg::FN_FIND) n_idx = '0;
            else n_idx = r_len;
            if ((r_func == iat_pkg::FN_SET_LEN) && (chk_status == iat_pkg::ST_OK) &&
                (pos_c <= len_c)) begin
                n_len = tgt_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= 32'sh8000_0000;
            r_max  <= 32'sh7FFF_FFFF;
            r_len  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_min  <= n_min;
            r_max  <= n_max;
            r_len  <= n_len;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_tgt     <= n_tgt;
        r_wr_addr <= n_wr_addr;
        r_status  <= n_status;
        r_rdata   <= n_rdata;
        r_fidx    <= n_fidx;
        if (i_cmd.capture) begin
            r_func <= iat_pkg::t_func'(i_func);
            r_pos  <= i_position;
            r_val  <= i_value;
        end
        if (i_cmd.load_out) begin
            r_o_status <= r_status;
            r_o_rdata  <= r_rdata;
            r_o_fidx   <= r_fidx;
            r_o_len    <= 7'(r_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    assign o_status      = r_o_status;
    assign o_read_data   = r_o_rdata;
    assign o_found_index = r_o_fidx;
    assign o_length_now  = r_o_len;

endmodule

`default_nettype wire

### hw/rtl/iat_ctrl.sv
// Controller: sequences request capture, check, memory sweep and response load.
`default_nettype none

module iat_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    output logic                  o_req_ready,
    input  wire logic             i_rsp_ready,
    output logic                  o_rsp_valid,
    output iat_pkg::t_dp_cmd      o_cmd,
    input  wire iat_pkg::t_dp_sts i_sts
);

    iat_pkg::t_state r_state, n_state;
    logic            r_rsp_valid, n_rsp_valid;
    logic            slot_free;

    assign slot_free = !r_rsp_valid || i_rsp_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            iat_pkg::S_IDLE: begin
                if (i_req_valid) n_state = iat_pkg::S_CHECK;
            end
            iat_pkg::S_CHECK: begin
                n_state = i_sts.run ? iat_pkg::S_RUN : iat_pkg::S_DONE;
            end
            iat_pkg::S_RUN: begin
                if (i_sts.done) n_state = iat_pkg::S_DONE;
            end
            iat_pkg::S_DONE: begin
                if (slot_free) n_state = iat_pkg::S_IDLE;
            end
            default: begin
                n_state = iat_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_req_ready    = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.start    = 1'b0;
        o_cmd.step     = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            iat_pkg::S_IDLE: begin
                o_req_ready   = i_rst_n;
                o_cmd.capture = i_req_valid && i_rst_n;
            end
            iat_pkg::S_CHECK: begin
                o_cmd.start = 1'b1;
            end
            iat_pkg::S_RUN: begin
                o_cmd.step = 1'b1;
            end
            iat_pkg::S_DONE: begin
                o_cmd.load_out = slot_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (o_cmd.load_out) n_rsp_valid = 1'b1;
        else if (i_rsp_ready) n_rsp_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iat_pkg::S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

`default_nettype wire

### hw/rtl/indexed_array_table_unit.sv
// Top level of the indexed array table: ordered array with insert, delete, read and find.
//
// Channels: i_req takes one request (func, position, value); o_rsp returns exactly one
// response (status, read_data, found_index, length_now) per request, in order; i_cfg
// writes min_value (index 0) or max_value (index 1) and is ready whenever reset is
// released. Write it only while no request is in flight.
// Steps: a check state, a run phase over the entry memory, and a load of the
// response register. The memory has one read and one write port; it moves, scans or
// clears one entry per cycle. Errors, shrinking the length and unused codes skip the
// run phase. One request is processed at a time; the next one is taken the cycle
// after the response register loads, even while that response waits on a stalled
// receiver; a stall holds the response and blocks only the load of the following one.
// Reset clears the length to zero, sets the limits to the full signed range, drops
// any pending response and holds both input channels not ready; entry contents are
// not cleared.
`default_nettype none

module indexed_array_table_unit #(
    parameter int DEPTH = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    iat_req_if.sink    i_req,
    iat_rsp_if.source  o_rsp,
    iat_cfg_if.sink    i_cfg
);

    iat_pkg::t_dp_cmd cmd;
    iat_pkg::t_dp_sts sts;

    assign i_cfg.ready = i_rst_n;

    iat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    iat_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_func        (i_req.func),
        .i_position    (i_req.position),
        .i_value       (i_req.value),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_status      (o_rsp.status),
        .o_read_data   (o_rsp.read_data),
        .o_found_index (o_rsp.found_index),
        .o_length_now  (o_rsp.length_now)
    );

endmodule

`default_nettype wire

### hw/rtl/iat_checker.sv
// Port-level checks for the indexed array table, bound to the top level.
`default_nettype none

module iat_checker #(
    parameter int DEPTH = 64
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_valid,
    input wire logic        i_req_ready,
    input wire logic        i_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic [2:0]  i_rsp_status,
    input wire logic [31:0] i_rsp_read_data,
    input wire logic [5:0]  i_rsp_found_index,
    input wire logic [6:0]  i_rsp_length_now
);

    a_rst_clears_rsp: assert property (@(posedge i_clk) !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while previous one in progress");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (int'(i_rsp_length_now) <= DEPTH))
        else $error("length above depth");

    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != iat_pkg::ST_OK))
        |-> ((i_rsp_read_data == 32'd0) && (i_rsp_found_index == 6'd0)))
        else $error("failed request returned data");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_status)
        && $stable(i_rsp_read_data) && $stable(i_rsp_length_now)))
        else $error("stalled response changed");

endmodule

bind indexed_array_table_unit iat_checker #(
    .DEPTH (DEPTH)
) u_iat_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_read_data   (o_rsp.read_data),
    .i_rsp_found_index (o_rsp.found_index),
    .i_rsp_length_now  (o_rsp.length_now)
);

`default_nettype wire
